// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page cache RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rmpc assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rmpc assertion failed");

`endif

// ----- sv/rmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rmpc_pkg
// Types and fixed constants of the randomized marking page cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmpc_pkg;

    localparam int PAGE_FIELD_W = 16;   // page_number / evicted_page field width
    localparam int RND_W        = 16;   // random_value field width
    localparam int STEP_W       = 4;    // counts the RND_W division steps
    localparam int CAP_W        = 5;    // capacity_in_use register width
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK,
        ST_DECIDE,
        ST_DIV,
        ST_CAND,
        ST_CLOAD,
        ST_RANK,
        ST_CHECK,
        ST_DONE
    } rmpc_state_t;

    // Status of the shared subtract/compare unit
    typedef struct packed {
        logic lt;
        logic eq;
    } rmpc_cmp_t;

    typedef struct packed {
        logic [PAGE_FIELD_W-1:0] evicted_page;
        logic                    evicted_valid;
        logic                    miss_cost;
    } rmpc_result_t;

endpackage

// ----- sv/rmpc_sub_unit.sv -----
// ----------------------------------------------------------------------------
// rmpc_sub_unit
// Shared subtractor: difference, borrow (a < b) and equality of two operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmpc_sub_unit #(
    parameter int W = 16
) (
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output logic [W-1:0]        diff,
    output rmpc_pkg::rmpc_cmp_t cmp
);
    import rmpc_pkg::*;

    logic [W:0] full;

    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[W-1:0];
    assign cmp.lt = full[W];
    assign cmp.eq = (full[W-1:0] == '0);

endmodule

// ----- sv/rmpc_slot_mem.sv -----
// ----------------------------------------------------------------------------
// rmpc_slot_mem
// Page number store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmpc_slot_mem #(
    parameter int DEPTH = 16,
    parameter int W     = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [W-1:0]             wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [W-1:0]             rd_data
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/randomized_marking_page_cache.sv -----
// ----------------------------------------------------------------------------
// randomized_marking_page_cache
// Fully associative page store run by the randomized marking policy.
// ----------------------------------------------------------------------------
// Each request names a page and brings a random value; one result comes back
// per request, from an output register, so the next request may be taken
// while a result still waits. One request is worked on at a time; page
// comparisons and the division's trial subtractions go through one shared
// subtractor under a small sequencer, with page numbers held in a
// single-read-port memory scanned one slot a cycle. A hit or a fill of a
// free slot takes a lookup scan, a decision and a hand-off. An eviction
// adds 16 division steps for the rank (random value modulo unmarked count)
// and then, for each slot tried as a candidate, a page read and a scan of
// all slots for rank counting (a slot that is no candidate is just skipped).
// The hand-off also holds for as long as the previous result still waits on
// m_tready. Capacity writes are taken at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module randomized_marking_page_cache #(
    parameter int MAX_SLOTS = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] page_number, [31:16] random_value
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] miss_cost, [1] evicted_valid,
                                   // [17:2] evicted_page, [23:18] zero
    // capacity_in_use write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import rmpc_pkg::*;

    localparam int IW   = $clog2(MAX_SLOTS);        // slot index width
    localparam int CW   = $clog2(MAX_SLOTS + 1);    // count width
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int UW   = (PAGE_BITS > CW + 1) ? PAGE_BITS : CW + 1;
    localparam logic [IW-1:0] LAST = IW'(MAX_SLOTS - 1);

    // State
    rmpc_state_t state_reg, state_next;

    logic [MAX_SLOTS-1:0] valid_reg,    valid_next;
    logic [MAX_SLOTS-1:0] unmarked_reg, unmarked_next;
    logic [CW-1:0]        occ_reg,      occ_next;
    logic [CAP_W-1:0]     cap_reg;
    logic                 out_vld_reg,  out_vld_next;
    logic                 issue_reg,    issue_next;
    logic                 rd_vld_reg,   rd_vld_next;

    // Payload
    logic [PAGE_BITS-1:0] req_reg,   req_next;
    logic [RND_W-1:0]     rnd_reg,   rnd_next;
    logic [PAGE_BITS-1:0] cand_page_reg, cand_page_next;
    logic [IW-1:0]        scan_idx_reg, scan_idx_next;
    logic [IW-1:0]        rd_idx_reg,   rd_idx_next;
    logic [IW-1:0]        hit_idx_reg,  hit_idx_next;
    logic [IW-1:0]        free_idx_reg, free_idx_next;
    logic [IW-1:0]        cand_idx_reg, cand_idx_next;
    logic                 hit_reg,      hit_next;
    logic                 free_fnd_reg, free_fnd_next;
    logic [CW-1:0]        cnt_reg,      cnt_next;
    logic [CW-1:0]        rem_reg,      rem_next;
    logic [CW-1:0]        rank_reg,     rank_next;
    logic [STEP_W-1:0]    step_reg,     step_next;
    rmpc_result_t         res_reg,      res_next;
    rmpc_result_t         out_reg,      out_next;

    // Memory and shared unit hookup
    logic                 mem_wr_en;
    logic [IW-1:0]        mem_wr_addr;
    logic                 mem_rd_en;
    logic [IW-1:0]        mem_rd_addr;
    logic [PAGE_BITS-1:0] mem_rd_data;
    logic [UW-1:0]        sub_a, sub_b, sub_diff;
    rmpc_cmp_t            sub_cmp;

    // Status
    logic                 scan_done;
    logic                 cand_ok;
    logic                 cand_last;
    logic                 step_last;
    logic                 room;
    logic                 out_free;
    logic [CW:0]          trial;
    logic [CMPW-1:0]      cap_ext, eff_cap;

    rmpc_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .W     (PAGE_BITS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (req_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rmpc_sub_unit #(
        .W (UW)
    ) u_sub (
        .a    (sub_a),
        .b    (sub_b),
        .diff (sub_diff),
        .cmp  (sub_cmp)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {6'b0, out_reg};

    // Clamp capacity to 1 .. MAX_SLOTS
    always_comb begin
        cap_ext = CMPW'(cap_reg);
        if (cap_reg == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > CMPW'(MAX_SLOTS)) begin
            eff_cap = CMPW'(MAX_SLOTS);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign room      = (CMPW'(occ_reg) < eff_cap);
    assign scan_done = rd_vld_reg && (rd_idx_reg == LAST);
    assign cand_ok   = valid_reg[cand_idx_reg] && unmarked_reg[cand_idx_reg];
    assign cand_last = (cand_idx_reg == LAST);
    assign step_last = (step_reg == STEP_W'(RND_W - 1));
    assign out_free  = !out_vld_reg || m_tready;
    assign trial     = {rem_reg, rnd_reg[RND_W-1]};

    // Operand select for the shared unit: page equality during lookup,
    // page ordering during rank counting, trial subtract during division.
    always_comb begin
        case (state_reg)
            ST_DIV: begin
                sub_a = UW'(trial);
                sub_b = UW'(cnt_reg);
            end
            ST_RANK: begin
                sub_a = UW'(mem_rd_data);
                sub_b = UW'(cand_page_reg);
            end
            default: begin
                sub_a = UW'(mem_rd_data);
                sub_b = UW'(req_reg);
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (scan_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (hit_reg || room || (cnt_reg == '0 && occ_reg == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_last) begin
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                if (cand_ok) begin
                    state_next = ST_CLOAD;
                end else if (cand_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLOAD: begin
                state_next = ST_RANK;
            end
            ST_RANK: begin
                if (scan_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (rank_reg == rem_reg || cand_last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CAND;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        valid_next     = valid_reg;
        unmarked_next  = unmarked_reg;
        occ_next       = occ_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_next       = out_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = scan_idx_reg;
        req_next       = req_reg;
        rnd_next       = rnd_reg;
        cand_page_next = cand_page_reg;
        scan_idx_next  = scan_idx_reg;
        hit_idx_next   = hit_idx_reg;
        free_idx_next  = free_idx_reg;
        cand_idx_next  = cand_idx_reg;
        hit_next       = hit_reg;
        free_fnd_next  = free_fnd_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        rank_next      = rank_reg;
        step_next      = step_reg;
        res_next       = res_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = free_idx_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = scan_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_next      = PAGE_BITS'(s_tdata[PAGE_FIELD_W-1:0]);
                    rnd_next      = s_tdata[PAGE_FIELD_W +: RND_W];
                    scan_idx_next = '0;
                    issue_next    = 1'b1;
                    hit_next      = 1'b0;
                    free_fnd_next = 1'b0;
                    cnt_next      = '0;
                    res_next      = '0;
                end
            end
            ST_LOOK, ST_RANK: begin
                // Issue one slot read a cycle; process the registered read data once rd_vld_reg marks it valid
                if (issue_reg) begin
                    mem_rd_en   = 1'b1;
                    rd_vld_next = 1'b1;
                    if (scan_idx_reg == LAST) begin
                        issue_next = 1'b0;
                    end else begin
                        scan_idx_next = scan_idx_reg + IW'(1);
                    end
                end
                if (rd_vld_reg && state_reg == ST_LOOK) begin
                    if (valid_reg[rd_idx_reg] && sub_cmp.eq) begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                    end
                    if (valid_reg[rd_idx_reg] && unmarked_reg[rd_idx_reg]) begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (!valid_reg[rd_idx_reg] && !free_fnd_reg) begin
                        free_fnd_next = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                if (rd_vld_reg && state_reg == ST_RANK) begin
                    if (valid_reg[rd_idx_reg] && unmarked_reg[rd_idx_reg] && sub_cmp.lt) begin
                        rank_next = rank_reg + CW'(1);
                    end
                end
            end
            ST_DECIDE: begin
                res_next.miss_cost = !hit_reg;
                if (hit_reg) begin
                    unmarked_next[hit_idx_reg] = 1'b0;
                end else if (room) begin
                    // Fill the first free slot, marked
                    mem_wr_en                   = 1'b1;
                    valid_next[free_idx_reg]    = 1'b1;
                    unmarked_next[free_idx_reg] = 1'b0;
                    occ_next                    = occ_reg + CW'(1);
                end else begin
                    // With no unmarked resident page left, start a new phase: unmark every resident page
                    if (cnt_reg == '0) begin
                        unmarked_next = valid_reg;
                        cnt_next      = occ_reg;
                    end
                    rem_next      = '0;
                    step_next     = '0;
                    cand_idx_next = '0;
                end
            end
            ST_DIV: begin
                // Restoring division, one bit of the random value a step
                if (sub_cmp.lt) begin
                    rem_next = trial[CW-1:0];
                end else begin
                    rem_next = sub_diff[CW-1:0];
                end
                rnd_next  = rnd_reg << 1;
                step_next = step_reg + STEP_W'(1);
            end
            ST_CAND: begin
                if (cand_ok) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cand_idx_reg;
                end else if (!cand_last) begin
                    cand_idx_next = cand_idx_reg + IW'(1);
                end
            end
            ST_CLOAD: begin
                cand_page_next = mem_rd_data;
                scan_idx_next  = '0;
                issue_next     = 1'b1;
                rank_next      = '0;
            end
            ST_CHECK: begin
                if (rank_reg == rem_reg) begin
                    // Evict the candidate, insert the request marked
                    mem_wr_en                   = 1'b1;
                    mem_wr_addr                 = cand_idx_reg;
                    unmarked_next[cand_idx_reg] = 1'b0;
                    res_next.evicted_valid      = 1'b1;
                    res_next.evicted_page       = PAGE_FIELD_W'(cand_page_reg);
                end else if (!cand_last) begin
                    cand_idx_next = cand_idx_reg + IW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_vld_next = 1'b1;
                    out_next     = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            unmarked_reg <= '0;
            occ_reg      <= '0;
            cap_reg      <= CAP_RESET;
            out_vld_reg  <= 1'b0;
            issue_reg    <= 1'b0;
            rd_vld_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            unmarked_reg <= unmarked_next;
            occ_reg      <= occ_next;
            out_vld_reg  <= out_vld_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        rnd_reg       <= rnd_next;
        cand_page_reg <= cand_page_next;
        scan_idx_reg  <= scan_idx_next;
        rd_idx_reg    <= rd_idx_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        cand_idx_reg  <= cand_idx_next;
        hit_reg       <= hit_next;
        free_fnd_reg  <= free_fnd_next;
        cnt_reg       <= cnt_next;
        rem_reg       <= rem_next;
        rank_reg      <= rank_next;
        step_reg      <= step_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // Occupancy tracks the resident pages exactly
    `ASSERT_IMP(a_occ_matches_valid, aclk, aresetn, 1'b1, $countones(valid_reg) == occ_reg)
    // Partial remainder stays below the divisor throughout the division
    `ASSERT_IMP(a_rem_below_cnt, aclk, aresetn, state_reg == ST_DIV, rem_reg < cnt_reg)
    // An eviction is always reported as a fault
    `ASSERT_IMP(a_evict_is_miss, aclk, aresetn, out_vld_reg && out_reg.evicted_valid, out_reg.miss_cost)
    // An accepted request starts the lookup scan
    `ASSERT_NXT(a_accept_starts_look, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_LOOK && issue_reg)

endmodule
